FILE: rtl/core/cqkr_pkg.sv
package cqkr_pkg;

   // Queue geometry
   localparam int DEPTH        = 16;
   localparam int KEY_BITS     = 32;
   localparam int PAYLOAD_BITS = 64;

   localparam int IDX_BITS   = $clog2(DEPTH);
   localparam int CNT_BITS   = $clog2(DEPTH + 1);
   localparam int ENTRY_BITS = KEY_BITS + PAYLOAD_BITS;

   // Port field widths
   localparam int CMD_BITS      = 3;
   localparam int ID_BITS       = 32;
   localparam int PAY_PORT_BITS = 64;
   localparam int OCC_BITS      = 5;

   typedef logic [IDX_BITS-1:0] idx_type;
   typedef logic [CNT_BITS-1:0] cnt_type;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_ENQUEUE = 3'd0,
      CMD_DEQUEUE = 3'd1,
      CMD_PEEK    = 3'd2,
      CMD_CLEAR   = 3'd3,
      CMD_REMOVE  = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_SHIFT_RD,
      ST_SHIFT_WR
   } state_type;

   // Entry store access from the sequencer
   typedef struct packed {
      logic                  wr_en;
      idx_type               wr_addr;
      logic [ENTRY_BITS-1:0] wr_data;
      idx_type               rd_addr;
   } ram_req_type;

   // Finished command, valid for the cycle in which done is high
   typedef struct packed {
      logic                    done;
      logic                    ok;
      status_type              status;
      logic [KEY_BITS-1:0]     out_key;
      logic [PAYLOAD_BITS-1:0] out_payload;
   } result_type;

   function automatic idx_type idx_fwd(idx_type i);
      return (i == idx_type'(DEPTH - 1)) ? '0 : i + idx_type'(1);
   endfunction

   function automatic idx_type idx_back(idx_type i);
      return (i == '0) ? idx_type'(DEPTH - 1) : i - idx_type'(1);
   endfunction

endpackage

FILE: rtl/core/cqkr_ram.sv
module cqkr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, register the read data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/cqkr_seq.sv
module cqkr_seq
   import cqkr_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [CMD_BITS-1:0]     cmd,
   input  logic [KEY_BITS-1:0]     key,
   input  logic [PAYLOAD_BITS-1:0] payload,
   input  logic [ENTRY_BITS-1:0]   rd_data,
   output logic                    busy,
   output ram_req_type             ram_req,
   output result_type              result,
   output cnt_type                 count
);

   state_type state_ff, state_in;
   idx_type   head_ff, head_in;
   idx_type   tail_ff, tail_in;
   cnt_type   count_ff, count_in;
   idx_type   pos_ff, pos_in;
   cnt_type   probe_ff, probe_in;

   logic [CMD_BITS-1:0]     cmd_ff;
   logic [KEY_BITS-1:0]     key_ff;
   logic [PAYLOAD_BITS-1:0] pay_ff;

   logic    accept;
   logic    is_empty;
   logic    is_full;
   logic    key_hit;
   logic    last_probe;
   logic    mid_hit;
   idx_type pos_fwd;

   assign accept     = start && (state_ff == ST_IDLE);
   assign busy       = (state_ff != ST_IDLE);
   assign is_empty   = (count_ff == '0);
   assign is_full    = (count_ff == cnt_type'(DEPTH));
   assign key_hit    = (rd_data[ENTRY_BITS-1 -: KEY_BITS] == key_ff);
   assign last_probe = ((probe_ff + cnt_type'(1)) == count_ff);
   assign mid_hit    = (pos_ff != head_ff) && (pos_ff != tail_ff);
   assign pos_fwd    = idx_fwd(pos_ff);
   assign count      = count_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            unique case (cmd_ff)
               CMD_DEQUEUE, CMD_PEEK: state_in = is_empty ? ST_IDLE : ST_READ;
               CMD_REMOVE:            state_in = is_empty ? ST_IDLE : ST_SRCH_RD;
               default:               state_in = ST_IDLE;
            endcase
         end
         ST_READ:     state_in = ST_IDLE;
         ST_SRCH_RD:  state_in = ST_SRCH_CMP;
         ST_SRCH_CMP: begin
            if (key_hit) begin
               state_in = mid_hit ? ST_SHIFT_RD : ST_IDLE;
            end else begin
               state_in = last_probe ? ST_IDLE : ST_SRCH_RD;
            end
         end
         ST_SHIFT_RD: state_in = ST_SHIFT_WR;
         ST_SHIFT_WR: state_in = (pos_fwd == tail_ff) ? ST_IDLE : ST_SHIFT_RD;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Datapath, store access and result
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      pos_in   = pos_ff;
      probe_in = probe_ff;
      ram_req  = '0;
      result   = '0;
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_EXEC: begin
            unique case (cmd_ff)
               CMD_ENQUEUE: begin
                  result.done = 1'b1;
                  if (is_full) begin
                     result.status = STAT_FULL;
                  end else begin
                     // first entry lands at the tail, later ones one past it
                     if (is_empty) begin
                        head_in = tail_ff;
                        ram_req.wr_addr = tail_ff;
                     end else begin
                        tail_in = idx_fwd(tail_ff);
                        ram_req.wr_addr = idx_fwd(tail_ff);
                     end
                     ram_req.wr_en   = 1'b1;
                     ram_req.wr_data = {key_ff, pay_ff};
                     count_in        = count_ff + cnt_type'(1);
                     result.ok       = 1'b1;
                  end
               end
               CMD_DEQUEUE, CMD_PEEK: begin
                  ram_req.rd_addr = head_ff;
                  if (is_empty) begin
                     result.done   = 1'b1;
                     result.status = STAT_EMPTY;
                  end
               end
               CMD_CLEAR: begin
                  head_in     = '0;
                  tail_in     = '0;
                  count_in    = '0;
                  result.done = 1'b1;
                  result.ok   = 1'b1;
               end
               CMD_REMOVE: begin
                  pos_in   = head_ff;
                  probe_in = '0;
                  if (is_empty) begin
                     result.done   = 1'b1;
                     result.status = STAT_EMPTY;
                  end
               end
               default: begin
                  result.done = 1'b1;
               end
            endcase
         end
         ST_READ: begin
            result.done        = 1'b1;
            result.ok          = 1'b1;
            result.out_key     = rd_data[ENTRY_BITS-1 -: KEY_BITS];
            result.out_payload = rd_data[PAYLOAD_BITS-1:0];
            if (cmd_ff == CMD_DEQUEUE) begin
               if (count_ff == cnt_type'(1)) begin
                  head_in  = '0;
                  tail_in  = '0;
                  count_in = '0;
               end else begin
                  head_in  = idx_fwd(head_ff);
                  count_in = count_ff - cnt_type'(1);
               end
            end
         end
         ST_SRCH_RD: begin
            ram_req.rd_addr = pos_ff;
         end
         ST_SRCH_CMP: begin
            if (key_hit) begin
               priority if ((pos_ff == head_ff) && (pos_ff == tail_ff)) begin
                  head_in     = '0;
                  tail_in     = '0;
                  count_in    = '0;
                  result.done = 1'b1;
                  result.ok   = 1'b1;
               end else if (pos_ff == head_ff) begin
                  head_in     = idx_fwd(head_ff);
                  count_in    = count_ff - cnt_type'(1);
                  result.done = 1'b1;
                  result.ok   = 1'b1;
               end else if (pos_ff == tail_ff) begin
                  tail_in     = idx_back(tail_ff);
                  count_in    = count_ff - cnt_type'(1);
                  result.done = 1'b1;
                  result.ok   = 1'b1;
               end else begin
                  // hit in the middle: close the gap in the shift loop
               end
            end else if (last_probe) begin
               result.done   = 1'b1;
               result.status = STAT_NOT_FOUND;
            end else begin
               pos_in   = pos_fwd;
               probe_in = probe_ff + cnt_type'(1);
            end
         end
         ST_SHIFT_RD: begin
            ram_req.rd_addr = pos_fwd;
         end
         ST_SHIFT_WR: begin
            // move the next entry one slot toward the head
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = pos_ff;
            ram_req.wr_data = rd_data;
            pos_in          = pos_fwd;
            if (pos_fwd == tail_ff) begin
               tail_in     = idx_back(tail_ff);
               count_in    = count_ff - cnt_type'(1);
               result.done = 1'b1;
               result.ok   = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         pos_ff   <= '0;
         probe_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         pos_ff   <= pos_in;
         probe_ff <= probe_in;
      end
   end

   // Hold the command on transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd;
         key_ff <= key;
         pay_ff <= payload;
      end
   end

endmodule

FILE: rtl/core/circular_queue_with_key_removal.sv
// Circular queue of DEPTH entries (key plus payload) with removal by key.
//
// Command channel: drive req_cmd, req_id and req_payload with start high; the
// transfer happens at the clock edge where start is high and busy is low.
// Commands: enqueue, dequeue, peek, clear, remove first entry matching req_id.
// Result channel: one result per command, on the rsp_ ports for exactly one
// cycle while rsp_valid is high. The receiver cannot stall; a new command may
// be issued in the cycle that carries the previous result.
//
// Steps of each command:
//   enqueue, clear, unknown code: finish in the execute state
//   dequeue, peek: one registered store read of the head entry, none when empty
//   remove: compare entries in turn from the head until a hit or the last one;
//           a hit in the middle shifts each later entry one slot toward the head
// The result is registered onto the rsp_ ports when the command finishes. Each
// compare and each shift step waits on one registered read of the entry store.
//
// Reset (synchronous, active high) empties the queue and drops any command
// in progress; stored entries are not cleared.
module circular_queue_with_key_removal
   import cqkr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [CMD_BITS-1:0]      req_cmd,
   input  logic [ID_BITS-1:0]       req_id,
   input  logic [PAY_PORT_BITS-1:0] req_payload,
   output logic                     rsp_valid,
   output logic                     rsp_ok,
   output logic [1:0]               rsp_status,
   output logic [ID_BITS-1:0]       rsp_out_id,
   output logic [PAY_PORT_BITS-1:0] rsp_out_payload,
   output logic [OCC_BITS-1:0]      rsp_occupancy,
   output logic                     rsp_is_empty,
   output logic                     rsp_is_full
);

   ram_req_type           ram_req;
   result_type            result;
   cnt_type               count;
   logic [ENTRY_BITS-1:0] rd_data;

   logic                     rsp_valid_ff;
   logic                     rsp_ok_ff;
   status_type               rsp_status_ff;
   logic [ID_BITS-1:0]       rsp_out_id_ff;
   logic [PAY_PORT_BITS-1:0] rsp_out_payload_ff;

   cqkr_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .cmd     (req_cmd),
      .key     (KEY_BITS'(req_id)),
      .payload (PAYLOAD_BITS'(req_payload)),
      .rd_data (rd_data),
      .busy    (busy),
      .ram_req (ram_req),
      .result  (result),
      .count   (count)
   );

   cqkr_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_addr (ram_req.rd_addr),
      .rd_data (rd_data)
   );

   // Strobe the result for one cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= result.done;
      end
   end

   // Capture result fields
   always_ff @(posedge clock) begin
      if (result.done) begin
         rsp_ok_ff          <= result.ok;
         rsp_status_ff      <= result.status;
         rsp_out_id_ff      <= ID_BITS'(result.out_key);
         rsp_out_payload_ff <= PAY_PORT_BITS'(result.out_payload);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_id      = rsp_out_id_ff;
   assign rsp_out_payload = rsp_out_payload_ff;

   // Occupancy holds its post-command value through the result cycle
   assign rsp_occupancy = OCC_BITS'(count);
   assign rsp_is_empty  = (count == '0);
   assign rsp_is_full   = (count == cnt_type'(DEPTH));

endmodule
